// File: rtl/gsrq_pkg.sv
`timescale 1ns / 1ps

package gsrq_pkg;

	// fixed field widths
	localparam int COORD_W     = 6;
	localparam int COLOUR_BITS = 3;
	localparam int RAD_W       = 3;
	localparam int DIM_W       = 7;
	localparam int CNT_W       = 13;

	// window coordinates reach a centre plus the radius, one bit past a coordinate
	localparam int SCAN_W      = COORD_W + 1;
	localparam int MAX_RADIUS  = 4;
	localparam int LIM_W       = 5;
	localparam int DIST_W      = 6;

	// grid size after reset
	localparam int DIM_RESET   = 64;

	// configuration register indexes
	localparam int CFG_IDX_W   = 1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

	// command queue between front and back
	localparam int Q_DEPTH     = 2;
	localparam int Q_PTR_W     = 1;

	typedef enum logic [1:0] {
		REQ_ADD  = 2'd0,
		REQ_READ = 2'd1,
		REQ_QANY = 2'd2,
		REQ_QCOL = 2'd3
	} req_t;

	typedef struct packed {
		req_t                   kind;
		logic [COORD_W-1:0]     row;
		logic [COORD_W-1:0]     col;
		logic [COLOUR_BITS-1:0] colour;
		logic                   in_grid;
		logic                   win_empty;
		logic [SCAN_W-1:0]      rlo;
		logic [SCAN_W-1:0]      rhi;
		logic [SCAN_W-1:0]      clo;
		logic [SCAN_W-1:0]      chi;
		logic [LIM_W-1:0]       lim;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} bk_ctrl_t;

	typedef enum logic [3:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_DIRECT,
		BK_ADD_RD,
		BK_ADD_WR,
		BK_READ_RD,
		BK_READ_OUT,
		BK_SCAN_PRIME,
		BK_SCAN,
		BK_FIN
	} bk_state_t;

endpackage

// File: rtl/gsrq_ram.sv
`timescale 1ns / 1ps

module gsrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/gsrq_front.sv
`timescale 1ns / 1ps

module gsrq_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      req_type,
	input  logic [gsrq_pkg::COORD_W-1:0]     row,
	input  logic [gsrq_pkg::COORD_W-1:0]     col,
	input  logic [gsrq_pkg::COLOUR_BITS-1:0] colour,
	input  logic [gsrq_pkg::RAD_W-1:0]       radius,
	input  logic [gsrq_pkg::DIM_W-1:0]       grid_rows,
	input  logic [gsrq_pkg::DIM_W-1:0]       grid_cols,
	input  gsrq_pkg::bk_ctrl_t               bk_ctrl,
	output gsrq_pkg::qhead_t                 head
);

	import gsrq_pkg::*;

	logic [RAD_W-1:0]   rad_sat;
	logic [SCAN_W-1:0]  row_x, col_x, rad_x, row_hi, col_hi;
	logic [SCAN_W-1:0]  rows_x, cols_x;
	logic [SCAN_W-1:0]  rlo, rhi, clo, chi;
	cmd_t               cmd_in;
	logic               push, full;
	cmd_t               q_mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_PTR_W:0]   cnt_q;

	// classify: saturate radius, clip the window, flag out-of-grid cells
	always_comb begin
		rad_sat = (radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius;
		row_x   = SCAN_W'(row);
		col_x   = SCAN_W'(col);
		rad_x   = SCAN_W'(rad_sat);
		rows_x  = SCAN_W'(grid_rows);
		cols_x  = SCAN_W'(grid_cols);
		row_hi  = row_x + rad_x;
		col_hi  = col_x + rad_x;
		rlo     = (row_x > rad_x) ? row_x - rad_x : '0;
		clo     = (col_x > rad_x) ? col_x - rad_x : '0;
		rhi     = (row_hi < rows_x) ? row_hi : rows_x - SCAN_W'(1);
		chi     = (col_hi < cols_x) ? col_hi : cols_x - SCAN_W'(1);

		cmd_in.kind      = req_t'(req_type);
		cmd_in.row       = row;
		cmd_in.col       = col;
		cmd_in.colour    = colour;
		cmd_in.in_grid   = (row_x < rows_x) && (col_x < cols_x);
		cmd_in.win_empty = (rlo > rhi) || (clo > chi);
		cmd_in.rlo       = rlo;
		cmd_in.rhi       = rhi;
		cmd_in.clo       = clo;
		cmd_in.chi       = chi;
		cmd_in.lim       = LIM_W'(rad_sat) * LIM_W'(rad_sat);
	end

	assign full       = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign in_stall   = full || bk_ctrl.clearing;
	assign push       = in_valid && !in_stall;
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (bk_ctrl.pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			unique case ({push, bk_ctrl.pop})
				2'b10:   cnt_q <= cnt_q + (Q_PTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (Q_PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

// File: rtl/gsrq_back.sv
`timescale 1ns / 1ps

module gsrq_back #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gsrq_pkg::qhead_t                 head,
	output gsrq_pkg::bk_ctrl_t               bk_ctrl,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            found,
	output logic [gsrq_pkg::COORD_W-1:0]     hit_row,
	output logic [gsrq_pkg::COORD_W-1:0]     hit_col,
	output logic [gsrq_pkg::COLOUR_BITS-1:0] hit_colour,
	output logic [gsrq_pkg::CNT_W-1:0]       occupied_total,
	output logic                            bad_coord,
	output logic                            last
);

	import gsrq_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	function automatic logic [AW-1:0] cell_addr(input logic [SCAN_W-1:0] r,
		input logic [SCAN_W-1:0] c);
		cell_addr = AW'(int'(r) * MAX_COLS + int'(c));
	endfunction

	bk_state_t              state_q, state_d;
	cmd_t                   cmd_q;
	logic [SCAN_W-1:0]      r_q, c_q, next_r, next_c;
	logic [SCAN_W-1:0]      row_x, col_x, dr, dc;
	logic [DIST_W-1:0]      dist_sq;
	logic                   pend_v_q;
	logic [COORD_W-1:0]     pend_row_q, pend_col_q;
	logic [COLOUR_BITS-1:0] pend_colour_q;
	logic [CNT_W-1:0]       count_q;
	logic [AW-1:0]          clr_addr_q, cur_addr;
	logic                   out_v_q, out_free;
	logic                   hit, last_cell;

	logic                   pop, push, advance, pend_take;
	logic                   p_found, p_bad, p_last;
	logic [COORD_W-1:0]     p_row, p_col;
	logic [COLOUR_BITS-1:0] p_colour;
	logic [CNT_W-1:0]       p_occ;

	logic                   mem_we;
	logic [AW-1:0]          mem_waddr, mem_raddr;
	logic [COLOUR_BITS-1:0] mem_wdata, mem_rdata;

	gsrq_ram #(
		.WIDTH (COLOUR_BITS),
		.DEPTH (DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign out_free = !out_v_q || !out_stall;
	assign cur_addr = cell_addr(SCAN_W'(cmd_q.row), SCAN_W'(cmd_q.col));

	// distance test for the cell whose colour is on the read port
	always_comb begin
		row_x     = SCAN_W'(cmd_q.row);
		col_x     = SCAN_W'(cmd_q.col);
		dr        = (r_q > row_x) ? r_q - row_x : row_x - r_q;
		dc        = (c_q > col_x) ? c_q - col_x : col_x - c_q;
		dist_sq   = DIST_W'(dr[RAD_W-1:0]) * DIST_W'(dr[RAD_W-1:0])
		          + DIST_W'(dc[RAD_W-1:0]) * DIST_W'(dc[RAD_W-1:0]);
		hit       = (dist_sq <= DIST_W'(cmd_q.lim)) && (mem_rdata != '0)
		          && ((cmd_q.kind == REQ_QANY) || (mem_rdata == cmd_q.colour));
		last_cell = (r_q == cmd_q.rhi) && (c_q == cmd_q.chi);
		if (c_q == cmd_q.chi) begin
			next_c = cmd_q.clo;
			next_r = r_q + SCAN_W'(1);
		end else begin
			next_c = c_q + SCAN_W'(1);
			next_r = r_q;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		push      = 1'b0;
		advance   = 1'b0;
		pend_take = 1'b0;
		p_found   = 1'b0;
		p_row     = cmd_q.row;
		p_col     = cmd_q.col;
		p_colour  = '0;
		p_occ     = count_q;
		p_bad     = 1'b0;
		p_last    = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = cmd_q.colour;
		mem_raddr = cell_addr(r_q, c_q);

		unique case (state_q)
			BK_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					unique case (head.cmd.kind)
						REQ_ADD: begin
							state_d = (head.cmd.in_grid && head.cmd.colour != '0) ?
								BK_ADD_RD : BK_DIRECT;
						end
						REQ_READ: begin
							state_d = head.cmd.in_grid ? BK_READ_RD : BK_DIRECT;
						end
						REQ_QANY, REQ_QCOL: begin
							state_d = head.cmd.win_empty ? BK_FIN : BK_SCAN_PRIME;
						end
						default: state_d = BK_IDLE;
					endcase
				end
			end
			BK_DIRECT: begin
				// ignored add or out-of-grid read: no grid access
				if (out_free) begin
					push    = 1'b1;
					p_bad   = !cmd_q.in_grid;
					state_d = BK_IDLE;
				end
			end
			BK_ADD_RD: begin
				mem_raddr = cur_addr;
				state_d   = BK_ADD_WR;
			end
			BK_ADD_WR: begin
				mem_raddr = cur_addr;
				if (out_free) begin
					mem_we  = 1'b1;
					push    = 1'b1;
					p_occ   = count_q + CNT_W'(mem_rdata == '0);
					state_d = BK_IDLE;
				end
			end
			BK_READ_RD: begin
				mem_raddr = cur_addr;
				state_d   = BK_READ_OUT;
			end
			BK_READ_OUT: begin
				mem_raddr = cur_addr;
				if (out_free) begin
					push     = 1'b1;
					p_colour = mem_rdata;
					p_found  = (mem_rdata != '0);
					state_d  = BK_IDLE;
				end
			end
			BK_SCAN_PRIME: begin
				state_d = BK_SCAN;
			end
			BK_SCAN: begin
				// one match is held back so the final one can carry last
				if (!(hit && pend_v_q && !out_free)) begin
					advance   = 1'b1;
					pend_take = hit;
					if (hit && pend_v_q) begin
						push     = 1'b1;
						p_found  = 1'b1;
						p_row    = pend_row_q;
						p_col    = pend_col_q;
						p_colour = pend_colour_q;
						p_last   = 1'b0;
					end
					mem_raddr = cell_addr(next_r, next_c);
					if (last_cell) begin
						state_d = BK_FIN;
					end
				end
			end
			BK_FIN: begin
				if (out_free) begin
					push = 1'b1;
					if (pend_v_q) begin
						p_found  = 1'b1;
						p_row    = pend_row_q;
						p_col    = pend_col_q;
						p_colour = pend_colour_q;
					end
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign bk_ctrl.pop      = pop;
	assign bk_ctrl.clearing = (state_q == BK_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_CLEAR;
			clr_addr_q <= '0;
			count_q    <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (push) begin
				count_q <= p_occ;
			end
			if (pop) begin
				pend_v_q <= 1'b0;
			end else if (pend_take) begin
				pend_v_q <= 1'b1;
			end else if (push && state_q == BK_FIN) begin
				pend_v_q <= 1'b0;
			end
			if (push) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head.cmd;
			r_q   <= head.cmd.rlo;
			c_q   <= head.cmd.clo;
		end else if (advance) begin
			r_q <= next_r;
			c_q <= next_c;
		end
		if (pend_take) begin
			pend_row_q    <= COORD_W'(r_q);
			pend_col_q    <= COORD_W'(c_q);
			pend_colour_q <= mem_rdata;
		end
		if (push) begin
			found          <= p_found;
			hit_row        <= p_row;
			hit_col        <= p_col;
			hit_colour     <= p_colour;
			occupied_total <= p_occ;
			bad_coord      <= p_bad;
			last           <= p_last;
		end
	end

	assign out_valid = out_v_q;

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("occupied count moved by more than one");

	a_quiet_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_CLEAR) |-> !out_v_q)
		else $error("result word offered during grid clear");

	a_scan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN && !advance) |=> (r_q == $past(r_q) && c_q == $past(c_q)))
		else $error("scan position moved while stalled");

	a_pend_scope: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (state_q == BK_SCAN || state_q == BK_FIN))
		else $error("held match outside a query");

endmodule

// File: rtl/grid_store_radius_query.sv
`timescale 1ns / 1ps

// Grid store with radius queries.
// Input channel (in_valid / in_stall) takes one request word: add a colour to a
// cell, read a cell, or query the clipped window around a centre for occupied
// cells (any colour or one colour) within the radius. Output channel
// (out_valid / out_stall) gives one result word per add or read, and one word
// per matching cell for a query, the final one flagged by last; a query with
// no match gives a single word with found low.
// With an idle engine, an add or read reads its cell from the grid before its word
// is offered; an ignored add, an out-of-grid read or a query whose window is
// clipped away skips the grid. A query walks its window one cell per cycle
// through the single read port of the grid memory, unless the output is stalled
// with a further match to offer; its final word is offered once the last cell
// of the window has been tested. Between two requests the engine passes
// through its idle state.
// A two-word command queue sits between the request front end and the grid
// engine, so up to two further requests are accepted while one is running.
// Reset: in_stall stays high while all MAX_ROWS * MAX_COLS cells (4096 by default)
// are swept to empty; grid_rows / grid_cols may be written then.
// A stalled output word holds; the engine halts once it has a further word to offer, until the stalled word is taken.
// Write grid_rows / grid_cols only while no request is in flight.
module grid_store_radius_query #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_wr_en,
	input  logic [gsrq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gsrq_pkg::DIM_W-1:0]        cfg_wdata,

	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        req_type,
	input  logic [gsrq_pkg::COORD_W-1:0]      row,
	input  logic [gsrq_pkg::COORD_W-1:0]      col,
	input  logic [gsrq_pkg::COLOUR_BITS-1:0]  colour,
	input  logic [gsrq_pkg::RAD_W-1:0]        radius,

	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic [gsrq_pkg::COORD_W-1:0]      hit_row,
	output logic [gsrq_pkg::COORD_W-1:0]      hit_col,
	output logic [gsrq_pkg::COLOUR_BITS-1:0]  hit_colour,
	output logic [gsrq_pkg::CNT_W-1:0]        occupied_total,
	output logic                              bad_coord,
	output logic                              last
);

	import gsrq_pkg::*;

	// zero reads as one, anything above the grid maximum as the maximum
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input int maxv);
		logic [DIM_W-1:0] res;
		priority if (v == '0) begin
			res = DIM_W'(1);
		end else if (int'(v) > maxv) begin
			res = DIM_W'(maxv);
		end else begin
			res = v;
		end
		return res;
	endfunction

	logic [DIM_W-1:0] grid_rows_q, grid_cols_q;
	qhead_t           head;
	bk_ctrl_t         bk_ctrl;

	// configuration registers, clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= clamp_dim(DIM_W'(DIM_RESET), MAX_ROWS);
			grid_cols_q <= clamp_dim(DIM_W'(DIM_RESET), MAX_COLS);
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_GRID_ROWS) begin
				grid_rows_q <= clamp_dim(cfg_wdata, MAX_ROWS);
			end
			if (cfg_index == REG_GRID_COLS) begin
				grid_cols_q <= clamp_dim(cfg_wdata, MAX_COLS);
			end
		end
	end

	// front end: accept, classify and queue the request word
	gsrq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.row       (row),
		.col       (col),
		.colour    (colour),
		.radius    (radius),
		.grid_rows (grid_rows_q),
		.grid_cols (grid_cols_q),
		.bk_ctrl   (bk_ctrl),
		.head      (head)
	);

	// back end: grid memory, scan engine and output register
	gsrq_back #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.bk_ctrl        (bk_ctrl),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.found          (found),
		.hit_row        (hit_row),
		.hit_col        (hit_col),
		.hit_colour     (hit_colour),
		.occupied_total (occupied_total),
		.bad_coord      (bad_coord),
		.last           (last)
	);

endmodule
